// ===== rtl/rdpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rdpm_pkg
// Types, constants and helper functions for the ramped dual PID motor mixer.
// ----------------------------------------------------------------------------
package rdpm_pkg;

  localparam int DT_SHIFT_DEF = 10;
  localparam int NUM_LOOPS    = 4;
  localparam int DATA_W       = 24;
  localparam int ERR_W        = 25;
  localparam int DIFF_W       = 26;
  localparam int INT_W        = 40;
  localparam int GAIN_W       = 16;
  localparam int STEP_W       = 16;
  localparam int EN_W         = 5;
  localparam int CFG_W        = 48;
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_GAINS_ANG  = 3'd1,
    REG_GAINS_LEFT = 3'd2,
    REG_GAINS_RGHT = 3'd3,
    REG_GAINS_MEAN = 3'd4,
    REG_ACCEL      = 3'd5,
    REG_DECEL      = 3'd6,
    REG_RATE_STEP  = 3'd7
  } cfg_reg_t;

  localparam int EN_CTRL  = 0;
  localparam int EN_ANG   = 1;
  localparam int EN_LEFT  = 2;
  localparam int EN_RIGHT = 3;
  localparam int EN_MEAN  = 4;

  localparam int LOOP_ANG   = 0;
  localparam int LOOP_LEFT  = 1;
  localparam int LOOP_RIGHT = 2;
  localparam int LOOP_MEAN  = 3;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] target_speed;
    logic signed [DATA_W-1:0] target_rate;
    logic signed [DATA_W-1:0] gyro_rate;
    logic signed [DATA_W-1:0] speed_left;
    logic signed [DATA_W-1:0] speed_right;
    logic signed [DATA_W-1:0] speed_mean;
    logic signed [DATA_W-1:0] side_wall_drive;
    logic signed [DATA_W-1:0] front_wall_drive;
    logic                     fail_safe;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] motor_left;
    logic signed [DATA_W-1:0] motor_right;
  } out_item_t;

  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh7FFFFF;
    lo = -64'sh800000;
    if (x > hi) begin
      return 24'sh7FFFFF;
    end else if (x < lo) begin
      return -24'sh800000;
    end
    return x[DATA_W-1:0];
  endfunction

  function automatic logic signed [INT_W-1:0] sat40(input logic signed [INT_W+1:0] x);
    logic signed [INT_W+1:0] hi;
    logic signed [INT_W+1:0] lo;
    hi = {3'b000, {(INT_W-1){1'b1}}};
    lo = {3'b111, {(INT_W-1){1'b0}}};
    if (x > hi) begin
      return hi[INT_W-1:0];
    end else if (x < lo) begin
      return lo[INT_W-1:0];
    end
    return x[INT_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] ramp(
    input logic signed [DATA_W-1:0] now,
    input logic signed [DATA_W-1:0] tgt,
    input logic        [STEP_W-1:0] up,
    input logic        [STEP_W-1:0] down
  );
    logic signed [DATA_W+1:0] n;
    logic signed [DATA_W+1:0] t;
    logic signed [DATA_W+1:0] s;
    n = (DATA_W+2)'(now);
    t = (DATA_W+2)'(tgt);
    s = n;
    if (t > n) begin
      s = n + $signed({10'b0, up});
      if (s > t) s = t;
    end else if (t < n) begin
      s = n - $signed({10'b0, down});
      if (s < t) s = t;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/rdpm_in_if.sv =====
// ----------------------------------------------------------------------------
// rdpm_in_if
// Input item channel: valid, ready and the tick payload.
// ----------------------------------------------------------------------------
interface rdpm_in_if;
  logic               valid;
  logic               ready;
  rdpm_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/rdpm_out_if.sv =====
// ----------------------------------------------------------------------------
// rdpm_out_if
// Result item channel: valid, ready and the motor duties.
// ----------------------------------------------------------------------------
interface rdpm_out_if;
  logic                valid;
  logic                ready;
  rdpm_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/rdpm_pid_term.sv =====
// ----------------------------------------------------------------------------
// rdpm_pid_term
// Product stage of one PID loop and the sum, scale and saturation after it.
// ----------------------------------------------------------------------------
module rdpm_pid_term #(
  parameter int DT_SHIFT = rdpm_pkg::DT_SHIFT_DEF
) (
  input  logic                                clk,
  input  logic                                load,
  input  rdpm_pkg::gains_t                    gains,
  input  logic signed [rdpm_pkg::ERR_W-1:0]   err,
  input  logic signed [rdpm_pkg::DIFF_W-1:0]  diff,
  input  logic signed [rdpm_pkg::INT_W-1:0]   integ,
  output logic signed [rdpm_pkg::DATA_W-1:0]  loop_out
);
  import rdpm_pkg::*;

  localparam int HALF = INT_W / 2;

  logic signed [GAIN_W+ERR_W:0]    p_r;
  logic signed [GAIN_W+DIFF_W:0]   d_r;
  logic signed [GAIN_W+HALF:0]     ih_r;
  logic        [GAIN_W+HALF-1:0]   il_r;

  logic signed [GAIN_W+INT_W:0]    i_full;
  logic signed [GAIN_W+INT_W:0]    i_part;
  logic signed [63:0]              acc;

  // ki * integral split in two halves to keep each multiplier narrow
  always_ff @(posedge clk) begin
    if (load) begin
      p_r  <= $signed({1'b0, gains.kp}) * err;
      d_r  <= $signed({1'b0, gains.kd}) * diff;
      ih_r <= $signed({1'b0, gains.ki}) * $signed(integ[INT_W-1:HALF]);
      il_r <= gains.ki * integ[HALF-1:0];
    end
  end

  always_comb begin
    i_full   = $signed({ih_r, {HALF{1'b0}}}) + $signed({1'b0, il_r});
    i_part   = i_full >>> (DT_SHIFT + 1);
    acc      = 64'(p_r) + (64'(d_r) <<< DT_SHIFT) + 64'(i_part);
    loop_out = sat24(acc >>> 8);
  end

endmodule

// ===== rtl/ramped_dual_pid_motor_mixer.sv =====
// ----------------------------------------------------------------------------
// ramped_dual_pid_motor_mixer
// Speed and turn-rate ramps, four PID loops and the differential motor mix.
// ----------------------------------------------------------------------------
// Stages: an accepted input item is held in stage a, then b, c (loop products) and d (result item).
// Throughput: one item per cycle; each stage has its own valid and stalls
//   only when the stage after it is full and not draining.
// Reset (rst_n low, synchronous): configuration, stage valids, ramps and loop state to zero.
// Inactive ticks clear the ramps and give no result.
// ----------------------------------------------------------------------------
module ramped_dual_pid_motor_mixer #(
  parameter int DT_SHIFT = rdpm_pkg::DT_SHIFT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  rdpm_in_if.sink                            in_ch,
  rdpm_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [rdpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rdpm_pkg::CFG_W-1:0]         cfg_data
);
  import rdpm_pkg::*;

  // configuration
  logic [EN_W-1:0]    en_r;
  gains_t             gains_r [NUM_LOOPS];
  logic [STEP_W-1:0]  accel_r;
  logic [STEP_W-1:0]  decel_r;
  logic [STEP_W-1:0]  rstep_r;

  // state
  logic signed [DATA_W-1:0] speed_r;
  logic signed [DATA_W-1:0] rate_r;
  logic signed [ERR_W-1:0]  err_st_r [NUM_LOOPS];
  logic signed [INT_W-1:0]  int_st_r [NUM_LOOPS];

  // pipeline
  logic                     a_v_r;
  in_item_t                 a_item_r;
  logic                     b_v_r;
  logic signed [ERR_W-1:0]  b_err_r  [NUM_LOOPS];
  logic signed [DIFF_W-1:0] b_diff_r [NUM_LOOPS];
  logic signed [INT_W-1:0]  b_int_r  [NUM_LOOPS];
  logic signed [ERR_W-1:0]  b_steer_r;
  logic                     c_v_r;
  logic signed [ERR_W-1:0]  c_steer_r;
  logic                     d_v_r;
  out_item_t                d_item_r;

  logic a_rdy, b_rdy, c_rdy, d_rdy;
  logic a_go, active;

  logic signed [DATA_W-1:0] spd_nxt;
  logic signed [DATA_W-1:0] rate_nxt;
  logic signed [DATA_W-1:0] tgt  [NUM_LOOPS];
  logic signed [DATA_W-1:0] meas [NUM_LOOPS];
  logic                     on   [NUM_LOOPS];
  logic signed [ERR_W-1:0]  err_nxt  [NUM_LOOPS];
  logic signed [DIFF_W-1:0] diff_nxt [NUM_LOOPS];
  logic signed [INT_W-1:0]  int_nxt  [NUM_LOOPS];

  logic signed [DATA_W-1:0] loop_o [NUM_LOOPS];
  logic signed [DATA_W-1:0] o_l, o_r;
  logic signed [ERR_W:0]    steer;
  out_item_t                d_item_nxt;

  assign d_rdy = !d_v_r || out_ch.ready;
  assign c_rdy = !c_v_r || d_rdy;
  assign b_rdy = !b_v_r || c_rdy;
  assign a_rdy = !a_v_r || b_rdy;
  assign a_go  = a_v_r && b_rdy;

  assign in_ch.ready  = a_rdy;
  assign out_ch.valid = d_v_r;
  assign out_ch.item  = d_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= '0;
      accel_r <= '0;
      decel_r <= '0;
      rstep_r <= '0;
      for (int k = 0; k < NUM_LOOPS; k++) gains_r[k] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE:     en_r             <= cfg_data[EN_W-1:0];
        REG_GAINS_ANG:  gains_r[LOOP_ANG]   <= cfg_data;
        REG_GAINS_LEFT: gains_r[LOOP_LEFT]  <= cfg_data;
        REG_GAINS_RGHT: gains_r[LOOP_RIGHT] <= cfg_data;
        REG_GAINS_MEAN: gains_r[LOOP_MEAN]  <= cfg_data;
        REG_ACCEL:      accel_r          <= cfg_data[STEP_W-1:0];
        REG_DECEL:      decel_r          <= cfg_data[STEP_W-1:0];
        REG_RATE_STEP:  rstep_r          <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // ramps and loop state update
  always_comb begin
    active   = en_r[EN_CTRL] && !a_item_r.fail_safe;
    spd_nxt  = ramp(speed_r, a_item_r.target_speed, accel_r, decel_r);
    rate_nxt = en_r[EN_ANG] ? ramp(rate_r, a_item_r.target_rate, rstep_r, rstep_r) : '0;

    tgt[LOOP_ANG]    = rate_nxt;
    tgt[LOOP_LEFT]   = spd_nxt;
    tgt[LOOP_RIGHT]  = spd_nxt;
    tgt[LOOP_MEAN]   = spd_nxt;
    meas[LOOP_ANG]   = a_item_r.gyro_rate;
    meas[LOOP_LEFT]  = a_item_r.speed_left;
    meas[LOOP_RIGHT] = a_item_r.speed_right;
    meas[LOOP_MEAN]  = a_item_r.speed_mean;
    on[LOOP_ANG]     = en_r[EN_ANG];
    on[LOOP_LEFT]    = en_r[EN_LEFT];
    on[LOOP_RIGHT]   = en_r[EN_RIGHT];
    on[LOOP_MEAN]    = en_r[EN_MEAN];

    for (int k = 0; k < NUM_LOOPS; k++) begin
      err_nxt[k]  = ERR_W'(tgt[k]) - ERR_W'(meas[k]);
      diff_nxt[k] = DIFF_W'(err_nxt[k]) - DIFF_W'(err_st_r[k]);
      int_nxt[k]  = sat40((INT_W+2)'(int_st_r[k]) + (INT_W+2)'(err_nxt[k])
                          + (INT_W+2)'(err_st_r[k]));
      if (!on[k]) begin
        err_nxt[k]  = '0;
        diff_nxt[k] = '0;
        int_nxt[k]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      speed_r <= '0;
      rate_r  <= '0;
      for (int k = 0; k < NUM_LOOPS; k++) begin
        err_st_r[k] <= '0;
        int_st_r[k] <= '0;
      end
    end else begin
      if (a_rdy) a_v_r <= in_ch.valid;
      if (b_rdy) b_v_r <= a_v_r && active;
      if (c_rdy) c_v_r <= b_v_r;
      if (d_rdy) d_v_r <= c_v_r;
      if (a_go) begin
        if (active) begin
          speed_r <= spd_nxt;
          rate_r  <= rate_nxt;
          for (int k = 0; k < NUM_LOOPS; k++) begin
            err_st_r[k] <= err_nxt[k];
            int_st_r[k] <= int_nxt[k];
          end
        end else begin
          speed_r <= '0;
          rate_r  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_ch.valid) a_item_r <= in_ch.item;
    if (a_go) begin
      b_steer_r <= ERR_W'(a_item_r.side_wall_drive) + ERR_W'(a_item_r.front_wall_drive);
      for (int k = 0; k < NUM_LOOPS; k++) begin
        b_err_r[k]  <= err_nxt[k];
        b_diff_r[k] <= diff_nxt[k];
        b_int_r[k]  <= int_nxt[k];
      end
    end
    if (b_v_r && c_rdy) c_steer_r <= b_steer_r;
    if (c_v_r && d_rdy) d_item_r  <= d_item_nxt;
  end

  for (genvar g = 0; g < NUM_LOOPS; g++) begin : g_loop
    rdpm_pid_term #(
      .DT_SHIFT (DT_SHIFT)
    ) u_term (
      .clk      (clk),
      .load     (b_v_r && c_rdy),
      .gains    (gains_r[g]),
      .err      (b_err_r[g]),
      .diff     (b_diff_r[g]),
      .integ    (b_int_r[g]),
      .loop_out (loop_o[g])
    );
  end

  // mix
  always_comb begin
    o_l   = en_r[EN_MEAN] ? loop_o[LOOP_MEAN] : loop_o[LOOP_LEFT];
    o_r   = en_r[EN_MEAN] ? loop_o[LOOP_MEAN] : loop_o[LOOP_RIGHT];
    steer = (ERR_W+1)'(c_steer_r) + (ERR_W+1)'(loop_o[LOOP_ANG]);
    d_item_nxt.motor_left  = sat24(64'(o_l) + 64'(steer));
    d_item_nxt.motor_right = sat24(64'(o_r) - 64'(steer));
  end

endmodule
